// ===== hw/rtl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants of the ordered list engine: operation codes,
// cell actions, scanner result and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package olist_pkg;

   // default configuration
   localparam int DEF_CAPACITY     = 64;
   localparam int DEF_KEY_BITS     = 32;
   localparam int DEF_PAYLOAD_BITS = 32;

   // fixed port field widths
   localparam int OPCODE_BITS = 3;
   localparam int POS_BITS    = 7;
   localparam int FIELD_BITS  = 32;
   localparam int INDEX_BITS  = 7;
   localparam int COUNT_BITS  = 7;

   // scanner looks at one group of cells per cycle
   localparam int GROUP_BITS = 3;
   localparam int GROUP      = 1 << GROUP_BITS;

   localparam logic [INDEX_BITS-1:0] NOT_FOUND = {INDEX_BITS{1'b1}};

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT   = 3'd0,
      OP_APPEND   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_REMOVE   = 3'd3,
      OP_FIND     = 3'd4,
      OP_CONTAINS = 3'd5,
      OP_READ     = 3'd6,
      OP_WRITE    = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_INSERT    = 3'd1,
      ACT_DELETE    = 3'd2,
      ACT_WRITE     = 3'd3,
      ACT_MATCH_KEY = 3'd4,
      ACT_MATCH_REC = 3'd5,
      ACT_MATCH_POS = 3'd6
   } cell_act_type;

   typedef struct packed {
      logic                  hit;
      logic [GROUP_BITS-1:0] slot;
   } scan_res_type;

endpackage

// ===== hw/rtl/olist_cell.sv =====
// ----------------------------------------------------------------------------
// olist_cell
// One slot of the list: holds a record, shifts with its neighbours on insert
// and delete, and flags a match for the scanner.
// ----------------------------------------------------------------------------
module olist_cell #(
   parameter int INDEX        = 0,
   parameter int IDX_W        = 7,
   parameter int KEY_BITS     = olist_pkg::DEF_KEY_BITS,
   parameter int PAYLOAD_BITS = olist_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  olist_pkg::cell_act_type  act,
   input  logic [IDX_W-1:0]         pos,
   input  logic [IDX_W-1:0]         last,
   input  logic [IDX_W-1:0]         count,
   input  logic [KEY_BITS-1:0]      new_key,
   input  logic [PAYLOAD_BITS-1:0]  new_payload,
   input  logic [KEY_BITS-1:0]      below_key,
   input  logic [PAYLOAD_BITS-1:0]  below_payload,
   input  logic [KEY_BITS-1:0]      above_key,
   input  logic [PAYLOAD_BITS-1:0]  above_payload,
   output logic [KEY_BITS-1:0]      key,
   output logic [PAYLOAD_BITS-1:0]  payload,
   output logic                     hit
);

   localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic                    hit_ff, hit_in;

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      hit_in = hit_ff;
      case (act)
         olist_pkg::ACT_INSERT: begin
            if (ME == pos) begin
               key_in = new_key;
               pay_in = new_payload;
            end else if (ME > pos && ME <= count) begin
               key_in = below_key;
               pay_in = below_payload;
            end
         end
         olist_pkg::ACT_DELETE: begin
            if (ME == last) begin
               key_in = '0;
               pay_in = '0;
            end else if (ME >= pos && ME < last) begin
               key_in = above_key;
               pay_in = above_payload;
            end
         end
         olist_pkg::ACT_WRITE: begin
            if (ME == pos) begin
               key_in = new_key;
               pay_in = new_payload;
            end
         end
         olist_pkg::ACT_MATCH_KEY: hit_in = (ME < count) && (key_ff == new_key);
         olist_pkg::ACT_MATCH_REC:
            hit_in = (ME < count) && (key_ff == new_key) && (pay_ff == new_payload);
         olist_pkg::ACT_MATCH_POS: hit_in = (ME == pos);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         pay_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         key_ff <= key_in;
         pay_ff <= pay_in;
         hit_ff <= hit_in;
      end
   end

   assign key     = key_ff;
   assign payload = pay_ff;
   assign hit     = hit_ff;

endmodule

// ===== hw/rtl/olist_scan.sv =====
// ----------------------------------------------------------------------------
// olist_scan
// Priority encoder over one group of cell match flags: lowest slot wins.
// ----------------------------------------------------------------------------
module olist_scan (
   input  logic [olist_pkg::GROUP-1:0] hits,
   output olist_pkg::scan_res_type     res
);

   always_comb begin
      res.hit  = |hits;
      res.slot = '0;
      for (int j = olist_pkg::GROUP - 1; j >= 0; j--) begin
         if (hits[j]) begin
            res.slot = olist_pkg::GROUP_BITS'(j);
         end
      end
   end

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine
// Fixed-capacity ordered list of key/payload records held in a row of cells.
// Insert, append, delete and write go from idle straight to the apply state;
// find, contains, read and remove pass through the match state, then scan
// the row group by group of 8 cells until one matches (at most ceil(CAPACITY/8)
// groups are scanned); a remove that hits then goes on to the apply state.
// Throughput: one transaction at a time; busy stays high until the result.
// The receiver cannot stall: each result is shown for one cycle on rsp_valid.
// Reset clears every slot and the count.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
   parameter int CAPACITY     = olist_pkg::DEF_CAPACITY,
   parameter int KEY_BITS     = olist_pkg::DEF_KEY_BITS,
   parameter int PAYLOAD_BITS = olist_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [olist_pkg::OPCODE_BITS-1:0]   req_opcode,
   input  logic [olist_pkg::POS_BITS-1:0]      req_position,
   input  logic [olist_pkg::FIELD_BITS-1:0]    req_key,
   input  logic [olist_pkg::FIELD_BITS-1:0]    req_payload,
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic signed [olist_pkg::INDEX_BITS-1:0] rsp_found_index,
   output logic [olist_pkg::FIELD_BITS-1:0]    rsp_read_key,
   output logic [olist_pkg::FIELD_BITS-1:0]    rsp_read_payload,
   output logic [olist_pkg::COUNT_BITS-1:0]    rsp_entry_count
);

   // count must hold CAPACITY itself; compares run at the wider of count and
   // position widths
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > olist_pkg::POS_BITS) ? CNT_W : olist_pkg::POS_BITS;
   localparam int NGRP   = (CAPACITY + olist_pkg::GROUP - 1) / olist_pkg::GROUP;
   localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int ADDR_W = GRP_W + olist_pkg::GROUP_BITS;
   localparam int PAD    = 1 << ADDR_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MATCH = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_APPLY = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   olist_pkg::opcode_type    op_ff, op_in, req_op;
   logic [CMP_W-1:0]         pos_ff, pos_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]  pay_ff, pay_in;
   logic [GRP_W-1:0]         grp_ff, grp_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_ok_ff, rsp_ok_in;
   logic [olist_pkg::INDEX_BITS-1:0]    rsp_found_ff, rsp_found_in;
   logic [olist_pkg::FIELD_BITS-1:0]    rsp_key_ff, rsp_key_in;
   logic [olist_pkg::FIELD_BITS-1:0]    rsp_pay_ff, rsp_pay_in;
   logic [olist_pkg::COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]         count_x, count_next_x, last_x, sel_idx;
   logic                     apply_ok;
   olist_pkg::cell_act_type  act;

   logic [KEY_BITS-1:0]      cell_key [CAPACITY];
   logic [PAYLOAD_BITS-1:0]  cell_pay [CAPACITY];
   logic [KEY_BITS-1:0]      key_pad  [PAD];
   logic [PAYLOAD_BITS-1:0]  pay_pad  [PAD];
   logic [PAD-1:0]           hit_pad;

   logic [olist_pkg::GROUP-1:0] grp_hits;
   olist_pkg::scan_res_type     scan_res;
   logic [ADDR_W-1:0]           sel_addr;

   assign req_op  = olist_pkg::opcode_type'(req_opcode);
   assign count_x = CMP_W'(count_ff);
   assign last_x  = count_x - CMP_W'(1);

   // -------------------------------------------------------------------------
   // Row of cells; each takes its neighbours' records when the list shifts.
   // -------------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]     below_key, above_key;
      logic [PAYLOAD_BITS-1:0] below_pay, above_pay;
      logic                    hit;

      if (i == 0) begin : g_first
         assign below_key = '0;
         assign below_pay = '0;
      end else begin : g_inner_lo
         assign below_key = cell_key[i-1];
         assign below_pay = cell_pay[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign above_key = '0;
         assign above_pay = '0;
      end else begin : g_inner_hi
         assign above_key = cell_key[i+1];
         assign above_pay = cell_pay[i+1];
      end

      olist_cell #(
         .INDEX        (i),
         .IDX_W        (CMP_W),
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .act           (act),
         .pos           (pos_ff),
         .last          (last_x),
         .count         (count_x),
         .new_key       (key_ff),
         .new_payload   (pay_ff),
         .below_key     (below_key),
         .below_payload (below_pay),
         .above_key     (above_key),
         .above_payload (above_pay),
         .key           (cell_key[i]),
         .payload       (cell_pay[i]),
         .hit           (hit)
      );

      assign hit_pad[i] = hit;
   end

   // pad the row to whole groups; padding never matches and reads as zero
   for (genvar i = 0; i < PAD; i++) begin : g_pad
      if (i < CAPACITY) begin : g_real
         assign key_pad[i] = cell_key[i];
         assign pay_pad[i] = cell_pay[i];
      end else begin : g_fill
         assign key_pad[i] = '0;
         assign pay_pad[i] = '0;
         assign hit_pad[i] = 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // Group scanner: one group of eight match flags per cycle.
   // -------------------------------------------------------------------------
   assign grp_hits = hit_pad[{grp_ff, {olist_pkg::GROUP_BITS{1'b0}}} +: olist_pkg::GROUP];

   olist_scan u_scan (
      .hits (grp_hits),
      .res  (scan_res)
   );

   assign sel_addr = {grp_ff, scan_res.slot};
   assign sel_idx  = CMP_W'(sel_addr);

   // -------------------------------------------------------------------------
   // Bounds checks for the operations that change the list.
   // -------------------------------------------------------------------------
   always_comb begin
      case (op_ff)
         olist_pkg::OP_INSERT,
         olist_pkg::OP_APPEND: apply_ok = (count_x < CMP_W'(CAPACITY)) && (pos_ff <= count_x);
         olist_pkg::OP_DELETE,
         olist_pkg::OP_REMOVE: apply_ok = (pos_ff < count_x);
         olist_pkg::OP_WRITE:  apply_ok = (pos_ff < CMP_W'(CAPACITY));
         default:              apply_ok = 1'b0;
      endcase
   end

   // drive the row: compare in the match cycle, shift or write in the apply cycle
   always_comb begin
      act = olist_pkg::ACT_NONE;
      case (state_ff)
         ST_MATCH: begin
            case (op_ff)
               olist_pkg::OP_FIND,
               olist_pkg::OP_REMOVE:   act = olist_pkg::ACT_MATCH_KEY;
               olist_pkg::OP_CONTAINS: act = olist_pkg::ACT_MATCH_REC;
               olist_pkg::OP_READ:     act = olist_pkg::ACT_MATCH_POS;
               default:                act = olist_pkg::ACT_NONE;
            endcase
         end
         ST_APPLY: begin
            if (apply_ok) begin
               case (op_ff)
                  olist_pkg::OP_INSERT,
                  olist_pkg::OP_APPEND: act = olist_pkg::ACT_INSERT;
                  olist_pkg::OP_DELETE,
                  olist_pkg::OP_REMOVE: act = olist_pkg::ACT_DELETE;
                  olist_pkg::OP_WRITE:  act = olist_pkg::ACT_WRITE;
                  default:              act = olist_pkg::ACT_NONE;
               endcase
            end
         end
         default: act = olist_pkg::ACT_NONE;
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      grp_in       = grp_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_found_in = rsp_found_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_count_in = rsp_count_ff;
      count_next_x = count_x;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // capture the transaction; append is an insert at the end
               op_in  = req_op;
               pos_in = (req_op == olist_pkg::OP_APPEND) ? count_x : CMP_W'(req_position);
               key_in = KEY_BITS'(req_key);
               pay_in = PAYLOAD_BITS'(req_payload);
               grp_in = '0;
               if (req_op inside {olist_pkg::OP_INSERT, olist_pkg::OP_APPEND,
                                  olist_pkg::OP_DELETE, olist_pkg::OP_WRITE}) begin
                  state_in = ST_APPLY;
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end

         ST_MATCH: begin
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            if (scan_res.hit) begin
               if (op_ff == olist_pkg::OP_REMOVE) begin
                  // hand the matching slot to the delete
                  pos_in   = sel_idx;
                  state_in = ST_APPLY;
               end else begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_count_in = count_x[olist_pkg::COUNT_BITS-1:0];
                  if (op_ff == olist_pkg::OP_READ) begin
                     rsp_found_in = olist_pkg::NOT_FOUND;
                     rsp_key_in   = olist_pkg::FIELD_BITS'(key_pad[sel_addr]);
                     rsp_pay_in   = olist_pkg::FIELD_BITS'(pay_pad[sel_addr]);
                  end else begin
                     rsp_found_in = sel_idx[olist_pkg::INDEX_BITS-1:0];
                     rsp_key_in   = '0;
                     rsp_pay_in   = '0;
                  end
               end
            end else if (grp_ff == GRP_W'(NGRP - 1)) begin
               // nothing matched anywhere in the row
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_found_in = olist_pkg::NOT_FOUND;
               rsp_key_in   = '0;
               rsp_pay_in   = '0;
               rsp_count_in = count_x[olist_pkg::COUNT_BITS-1:0];
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end

         ST_APPLY: begin
            if (apply_ok) begin
               case (op_ff)
                  olist_pkg::OP_INSERT,
                  olist_pkg::OP_APPEND: count_in = count_ff + CNT_W'(1);
                  olist_pkg::OP_DELETE,
                  olist_pkg::OP_REMOVE: count_in = count_ff - CNT_W'(1);
                  default:              count_in = count_ff;
               endcase
            end
            count_next_x = CMP_W'(count_in);
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = apply_ok;
            rsp_found_in = (op_ff == olist_pkg::OP_REMOVE) ?
                           pos_ff[olist_pkg::INDEX_BITS-1:0] : olist_pkg::NOT_FOUND;
            rsp_key_in   = '0;
            rsp_pay_in   = '0;
            rsp_count_in = count_next_x[olist_pkg::COUNT_BITS-1:0];
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction and result payload: no reset needed
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      pay_ff       <= pay_in;
      grp_ff       <= grp_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_found_index  = $signed(rsp_found_ff);
   assign rsp_read_key     = rsp_key_ff;
   assign rsp_read_payload = rsp_pay_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

// ===== tb/olist_checker.sv =====
// ----------------------------------------------------------------------------
// olist_checker
// Watches the command and result channels of the ordered list engine, keeps
// its own copy of the list, works out the expected result of every accepted
// transaction and compares each result against the oldest one waiting.
// ----------------------------------------------------------------------------
module olist_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [olist_pkg::OPCODE_BITS-1:0]      req_opcode,
   input  logic [olist_pkg::POS_BITS-1:0]         req_position,
   input  logic [olist_pkg::FIELD_BITS-1:0]       req_key,
   input  logic [olist_pkg::FIELD_BITS-1:0]       req_payload,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ok,
   input  logic signed [olist_pkg::INDEX_BITS-1:0] rsp_found_index,
   input  logic [olist_pkg::FIELD_BITS-1:0]       rsp_read_key,
   input  logic [olist_pkg::FIELD_BITS-1:0]       rsp_read_payload,
   input  logic [olist_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   output int                                     failures,
   output int                                     pending,
   output int                                     checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import olist_pkg::*;

   localparam int SLOTS     = DEF_CAPACITY;
   localparam int SLOT_BITS = $clog2(SLOTS);

   typedef struct packed {
      logic                  ok;
      logic [INDEX_BITS-1:0] index;
      logic [FIELD_BITS-1:0] rkey;
      logic [FIELD_BITS-1:0] rpay;
      logic [COUNT_BITS-1:0] count;
   } outcome_type;

   logic [FIELD_BITS-1:0] list_keys [SLOTS];
   logic [FIELD_BITS-1:0] list_pays [SLOTS];
   int                    held = 0;
   outcome_type           awaited_outcomes [$];
   int                    mismatches = 0;
   int                    compared = 0;

   function automatic int first_index(logic [FIELD_BITS-1:0] k, logic [FIELD_BITS-1:0] p,
                                      bit need_pay);
      for (int i = 0; i < held; i++)
         if (list_keys[i] == k && (!need_pay || list_pays[i] == p))
            return i;
      return -1;
   endfunction

   // open a gap at 'at' and drop the record into it
   function automatic bit shift_in(int at, logic [FIELD_BITS-1:0] k,
                                   logic [FIELD_BITS-1:0] p);
      if (held >= SLOTS || at > held)
         return 1'b0;
      for (int i = held; i > at; i--) begin
         list_keys[i] = list_keys[i-1];
         list_pays[i] = list_pays[i-1];
      end
      list_keys[at] = k;
      list_pays[at] = p;
      held++;
      return 1'b1;
   endfunction

   // close the gap at 'at' and clear the slot left free at the top
   function automatic bit shift_out(int at);
      if (held == 0 || at >= held)
         return 1'b0;
      for (int i = at; i + 1 < held; i++) begin
         list_keys[i] = list_keys[i+1];
         list_pays[i] = list_pays[i+1];
      end
      list_keys[held-1] = '0;
      list_pays[held-1] = '0;
      held--;
      return 1'b1;
   endfunction

   function automatic outcome_type predict_outcome(opcode_type op, logic [POS_BITS-1:0] pos,
                                                   logic [FIELD_BITS-1:0] k,
                                                   logic [FIELD_BITS-1:0] p);
      outcome_type          o;
      int                   idx;
      logic [SLOT_BITS-1:0] slot;
      o    = '0;
      idx  = -1;
      slot = pos[SLOT_BITS-1:0];
      case (op)
         OP_INSERT: o.ok = shift_in(int'(pos), k, p);
         OP_APPEND: o.ok = shift_in(held, k, p);
         OP_DELETE: o.ok = shift_out(int'(pos));
         OP_REMOVE: begin
            idx = first_index(k, p, 1'b0);
            if (idx >= 0)
               o.ok = shift_out(idx);
         end
         OP_FIND: begin
            idx  = first_index(k, p, 1'b0);
            o.ok = idx >= 0;
         end
         OP_CONTAINS: begin
            idx  = first_index(k, p, 1'b1);
            o.ok = idx >= 0;
         end
         OP_READ: begin
            if (int'(pos) < SLOTS) begin
               o.rkey = list_keys[slot];
               o.rpay = list_pays[slot];
               o.ok   = 1'b1;
            end
         end
         default: begin
            if (int'(pos) < SLOTS) begin
               list_keys[slot] = k;
               list_pays[slot] = p;
               o.ok            = 1'b1;
            end
         end
      endcase
      o.index = (idx < 0) ? NOT_FOUND : idx[INDEX_BITS-1:0];
      o.count = held[COUNT_BITS-1:0];
      return o;
   endfunction

   task automatic compare_field(string field, logic [FIELD_BITS-1:0] want,
                                logic [FIELD_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type seen;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            list_keys[i] = '0;
            list_pays[i] = '0;
         end
         held = 0;
         awaited_outcomes.delete();
      end else begin
         // retire the result first: a new command may be taken on the same edge
         if (rsp_valid) begin
            seen.ok    = rsp_ok;
            seen.index = rsp_found_index;
            seen.rkey  = rsp_read_key;
            seen.rpay  = rsp_read_payload;
            seen.count = rsp_entry_count;
            if (awaited_outcomes.size() == 0) begin
               $error("result seen with no transaction outstanding");
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("ok", want.ok, seen.ok);
               compare_field("found_index", want.index, seen.index);
               compare_field("read_key", want.rkey, seen.rkey);
               compare_field("read_payload", want.rpay, seen.rpay);
               compare_field("entry_count", want.count, seen.count);
               compared++;
            end
         end
         if (start && !busy)
            awaited_outcomes.push_back(predict_outcome(opcode_type'(req_opcode), req_position,
                                                       req_key, req_payload));
      end
      failures <= mismatches;
      pending  <= awaited_outcomes.size();
      checked  <= compared;
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ordered list engine: a directed opening that
// walks the edge cases, then a long stretch of random commands steered to fill
// and drain the list, sent in bursts with random gaps. Checking is done by
// olist_checker, which sits beside the engine.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import olist_pkg::*;

   localparam int SLOTS        = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT  = 200000;

   // grow: mostly inserts, shrink: mostly deletions, mixed: anything
   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} steer_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [OPCODE_BITS-1:0]  req_opcode = '0;
   logic [POS_BITS-1:0]     req_position = '0;
   logic [FIELD_BITS-1:0]   req_key = '0;
   logic [FIELD_BITS-1:0]   req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ok;
   logic signed [INDEX_BITS-1:0] rsp_found_index;
   logic [FIELD_BITS-1:0]   rsp_read_key;
   logic [FIELD_BITS-1:0]   rsp_read_payload;
   logic [COUNT_BITS-1:0]   rsp_entry_count;

   int failures;
   int pending;
   int checked;

   // stimulus bookkeeping, used only to steer and summarise
   int                    occupancy = 0;
   int                    full_results = 0;
   int                    issued = 0;
   int                    op_tally [8];
   logic [FIELD_BITS-1:0] key_pool [12];
   logic [FIELD_BITS-1:0] pay_pool [4];

   always #1 clock = ~clock;

   ordered_list_engine uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_key          (req_key),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_found_index  (rsp_found_index),
      .rsp_read_key     (rsp_read_key),
      .rsp_read_payload (rsp_read_payload),
      .rsp_entry_count  (rsp_entry_count)
   );

   olist_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_key          (req_key),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_found_index  (rsp_found_index),
      .rsp_read_key     (rsp_read_key),
      .rsp_read_payload (rsp_read_payload),
      .rsp_entry_count  (rsp_entry_count),
      .failures         (failures),
      .pending          (pending),
      .checked          (checked)
   );

   // track the list size as the engine reports it, to steer the random part
   always @(posedge clock) begin
      if (rsp_valid) begin
         occupancy <= int'(rsp_entry_count);
         if (int'(rsp_entry_count) == SLOTS)
            full_results <= full_results + 1;
      end
   end

   // Present one transaction and hold it until the engine takes it. Start is
   // left high on return so that a following command goes out back to back.
   task automatic send_command(opcode_type op, logic [POS_BITS-1:0] pos,
                               logic [FIELD_BITS-1:0] k, logic [FIELD_BITS-1:0] p);
      start        <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_key      <= k;
      req_payload  <= p;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      issued++;
      op_tally[op]++;
   endtask

   // Drop start for a number of cycles, with noise on the idle fields.
   task automatic hold_off(int unsigned idle_cycles);
      start <= 1'b0;
      repeat (idle_cycles) begin
         req_opcode   <= OPCODE_BITS'($urandom);
         req_position <= POS_BITS'($urandom);
         req_key      <= $urandom;
         req_payload  <= $urandom;
         @(posedge clock);
      end
   endtask

   // Stop sending until every outstanding result has come back.
   task automatic drain_outstanding();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // guard against a hung engine
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      steer_mode_type        mode;
      int                    burst_left;
      int                    pick;
      opcode_type            op;
      logic [POS_BITS-1:0]   pos;
      logic [FIELD_BITS-1:0] k;
      logic [FIELD_BITS-1:0] p;

      foreach (op_tally[i])
         op_tally[i] = 0;
      // keep keys and payloads from small pools most of the time so that
      // find, contains and remove actually hit, duplicates included
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 12; i++)
         key_pool[i] = $urandom;
      pay_pool[0] = '0;
      pay_pool[1] = '1;
      pay_pool[2] = $urandom;
      pay_pool[3] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed opening ----
      // empty list: reads give zero, deletions and searches fail
      send_command(OP_READ, 7'd0, '0, '0);
      send_command(OP_READ, 7'd127, '1, '1);
      send_command(OP_DELETE, 7'd0, '0, '0);
      send_command(OP_REMOVE, 7'd0, '0, '0);
      send_command(OP_FIND, 7'd0, '0, '0);
      send_command(OP_CONTAINS, 7'd0, '0, '0);
      // insert past the count is refused
      send_command(OP_INSERT, 7'd1, 32'h1234_5678, 32'h9abc_def0);
      // build a short list with extreme values and a duplicated key
      send_command(OP_INSERT, 7'd0, '1, '1);
      send_command(OP_APPEND, 7'd0, '0, '0);
      send_command(OP_INSERT, 7'd1, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
      send_command(OP_APPEND, 7'd127, '1, 32'd1);
      send_command(OP_FIND, 7'd0, '1, '0);
      send_command(OP_CONTAINS, 7'd0, '1, 32'd1);
      send_command(OP_CONTAINS, 7'd0, '1, 32'd2);
      // writes and reads at and past the capacity, and past the count
      send_command(OP_WRITE, 7'd127, 32'hdead_beef, 32'hcafe_f00d);
      send_command(OP_WRITE, 7'd63, 32'h0bad_f00d, 32'h8000_0001);
      send_command(OP_READ, 7'd63, '0, '0);
      send_command(OP_READ, 7'd64, '0, '0);
      // insert just beyond the count, then exactly at it
      send_command(OP_INSERT, 7'd5, 32'h7777_7777, 32'h1111_1111);
      send_command(OP_INSERT, 7'd4, 32'h7777_7777, 32'h1111_1111);
      // remove reports the index the key held before removal
      send_command(OP_REMOVE, 7'd0, '1, '0);
      send_command(OP_DELETE, 7'd4, '0, '0);
      send_command(OP_DELETE, 7'd3, '0, '0);
      send_command(OP_DELETE, 7'd0, '0, '0);
      // the vacated slot reads back as zero
      send_command(OP_READ, 7'd3, '0, '0);
      drain_outstanding();

      // ---- random part ----
      mode       = MODE_GROW;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            // occasional long stretch with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
               hold_off($urandom_range(1, 10));
         end
         burst_left--;

         // steer: fill to capacity, sit there a while, then drain
         if (mode == MODE_GROW && occupancy >= SLOTS && $urandom_range(0, 5) == 0)
            mode = MODE_SHRINK;
         else if (mode == MODE_SHRINK && occupancy == 0 && $urandom_range(0, 3) == 0)
            mode = ($urandom_range(0, 1) == 0) ? MODE_GROW : MODE_MIXED;
         else if ($urandom_range(0, 79) == 0)
            mode = steer_mode_type'($urandom_range(0, 2));

         pick = $urandom_range(0, 99);
         case (mode)
            MODE_GROW:
               op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_APPEND :
                    (pick < 69) ? OP_DELETE : (pick < 73) ? OP_REMOVE :
                    (pick < 81) ? OP_FIND   : (pick < 88) ? OP_CONTAINS :
                    (pick < 94) ? OP_READ   : OP_WRITE;
            MODE_SHRINK:
               op = (pick < 5)  ? OP_INSERT : (pick < 10) ? OP_APPEND :
                    (pick < 42) ? OP_DELETE : (pick < 68) ? OP_REMOVE :
                    (pick < 78) ? OP_FIND   : (pick < 86) ? OP_CONTAINS :
                    (pick < 94) ? OP_READ   : OP_WRITE;
            default:
               op = opcode_type'($urandom_range(0, 7));
         endcase

         // positions: mostly inside the list or just at its end, sometimes
         // around the capacity or anywhere in the field
         pick = $urandom_range(0, 9);
         if (pick < 7)
            pos = POS_BITS'($urandom_range(0, occupancy));
         else if (pick == 7)
            pos = POS_BITS'(occupancy + 1);
         else if (pick == 8)
            pos = POS_BITS'(SLOTS - 1 + $urandom_range(0, 1)) | (($urandom_range(0, 1) == 0)
                  ? 7'd0 : 7'h7f);
         else
            pos = POS_BITS'($urandom);

         k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 11)] : $urandom;
         p = ($urandom_range(0, 9) < 6) ? pay_pool[$urandom_range(0, 3)] : $urandom;

         send_command(op, pos, k, p);

         // let the engine run dry now and then
         if (n % 150 == 149)
            drain_outstanding();
      end

      drain_outstanding();
      repeat (16) @(posedge clock);

      $display("summary: %0d transactions sent, %0d results checked, %0d results at full capacity",
               issued, checked, full_results);
      $display("summary: ins %0d app %0d del %0d rem %0d find %0d cont %0d rd %0d wr %0d",
               op_tally[OP_INSERT], op_tally[OP_APPEND], op_tally[OP_DELETE],
               op_tally[OP_REMOVE], op_tally[OP_FIND], op_tally[OP_CONTAINS],
               op_tally[OP_READ], op_tally[OP_WRITE]);
      if (failures == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
